@@ hw/rtl/dmrc_pkg.sv @@
`default_nettype none
package dmrc_pkg;

	localparam int unsigned DEF_MAP_DEPTH   = 64;
	localparam int unsigned DEF_ECAM_DEPTH  = 8;
	localparam int unsigned DEF_GUARD_DEPTH = 32;
	localparam int unsigned DEF_PAGE_BITS   = 12;
	localparam int unsigned ECAM_BUS_SHIFT  = 20;

	localparam logic [63:0] APER_LOW_BASE_RST  = 64'h0000_0000_C000_0000;
	localparam logic [63:0] APER_LOW_END_RST   = 64'h0000_0000_FEC0_0000;
	localparam logic [63:0] APER_HIGH_BASE_RST = 64'h0000_0008_0000_0000;
	localparam logic [63:0] APER_HIGH_END_RST  = 64'h0000_0010_0000_0000;

	typedef enum logic [1:0] {
		CFG_APER_LOW_BASE  = 2'd0,
		CFG_APER_LOW_END   = 2'd1,
		CFG_APER_HIGH_BASE = 2'd2,
		CFG_APER_HIGH_END  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		REQ_MAP      = 2'd0,
		REQ_ECAM     = 2'd1,
		REQ_PROTECT  = 2'd2,
		REQ_VALIDATE = 2'd3
	} req_kind_t;

	localparam logic [3:0] MEM_CONV    = 4'd7;
	localparam logic [3:0] MEM_RECLAIM = 4'd9;
	localparam logic [3:0] MEM_NVS     = 4'd10;
	localparam logic [3:0] MEM_MMIO    = 4'd11;

	localparam int unsigned FL_READ  = 0;
	localparam int unsigned FL_WRITE = 1;
	localparam int unsigned FL_WC    = 2;
	localparam int unsigned FL_FW    = 3;

	localparam logic [1:0] CLASS_NONE     = 2'd0;
	localparam logic [1:0] CLASS_PRISTINE = 2'd1;
	localparam logic [1:0] CLASS_UC       = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [63:0] base;
		logic [63:0] length;
		logic [63:0] pages;
		logic [3:0]  mem_type;
		logic [7:0]  flags;
		logic [7:0]  first_bus;
		logic [7:0]  end_bus;
	} req_t;

	typedef struct packed {
		logic       ok;
		logic [1:0] mapping_class;
		logic       delegatable;
	} rsp_t;

	typedef enum logic [1:0] {
		TBL_GUARD = 2'd0,
		TBL_MAP   = 2'd1,
		TBL_ECAM  = 2'd2
	} tbl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_CHECK,
		ST_GUARD,
		ST_MAP,
		ST_ECAM,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic latch;
		logic prep;
		logic wr_en;
		logic scan_start;
		tbl_t tbl;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       rng_ok;
		logic       bus_ok;
		logic       flags_ok;
		logic       fw_req;
		logic       wr_req;
		logic       full;
		logic       busy;
		logic       guard_hit;
		logic       conv_hit;
		logic       mmio_in;
		logic       fw_in;
		logic       ecam_found;
		logic       ecam_in;
		logic       aper_in;
	} sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/device_mapping_range_checker_core.sv @@
`default_nettype none
// Checks physical device mapping requests against three tables (firmware map entries, ECAM
// windows, protected ranges), each filled by its own request kind; one result per
// transaction. A validate walks the protected ranges, then the map entries, then the ECAM
// windows, and ends early when it is rejected or is a firmware request: each table is
// walked one entry per cycle through its memory read port behind a two-stage compare.
// One request is in work at a time; a finished result waits in the output register while
// the next request is taken, and the next result waits until it is taken. The user must
// write the aperture registers only while the block is idle; the block itself does not
// enforce this.
module device_mapping_range_checker_core #(
	parameter int unsigned MAP_DEPTH   = dmrc_pkg::DEF_MAP_DEPTH,
	parameter int unsigned ECAM_DEPTH  = dmrc_pkg::DEF_ECAM_DEPTH,
	parameter int unsigned GUARD_DEPTH = dmrc_pkg::DEF_GUARD_DEPTH,
	parameter int unsigned PAGE_BITS   = dmrc_pkg::DEF_PAGE_BITS
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire dmrc_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output dmrc_pkg::rsp_t      rsp,
	input  wire logic           cfg_we,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [63:0]    cfg_data
);
	import dmrc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	dmrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.sts       (sts),
		.cmd       (cmd)
	);

	dmrc_dp #(
		.MAP_DEPTH   (MAP_DEPTH),
		.ECAM_DEPTH  (ECAM_DEPTH),
		.GUARD_DEPTH (GUARD_DEPTH),
		.PAGE_BITS   (PAGE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
`default_nettype wire

@@ hw/rtl/dmrc_dp.sv @@
`default_nettype none
module dmrc_dp #(
	parameter int unsigned MAP_DEPTH   = dmrc_pkg::DEF_MAP_DEPTH,
	parameter int unsigned ECAM_DEPTH  = dmrc_pkg::DEF_ECAM_DEPTH,
	parameter int unsigned GUARD_DEPTH = dmrc_pkg::DEF_GUARD_DEPTH,
	parameter int unsigned PAGE_BITS   = dmrc_pkg::DEF_PAGE_BITS
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire dmrc_pkg::req_t req,
	input  wire logic           cfg_we,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [63:0]    cfg_data,
	input  wire dmrc_pkg::cmd_t cmd,
	output dmrc_pkg::sts_t      sts
);
	import dmrc_pkg::*;

	localparam int unsigned MAP_CW   = $clog2(MAP_DEPTH + 1);
	localparam int unsigned ECAM_CW  = $clog2(ECAM_DEPTH + 1);
	localparam int unsigned GUARD_CW = $clog2(GUARD_DEPTH + 1);
	localparam int unsigned MAP_AW   = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int unsigned ECAM_AW  = (ECAM_DEPTH > 1) ? $clog2(ECAM_DEPTH) : 1;
	localparam int unsigned GUARD_AW = (GUARD_DEPTH > 1) ? $clog2(GUARD_DEPTH) : 1;
	localparam int unsigned IW_A     = (MAP_CW > ECAM_CW) ? MAP_CW : ECAM_CW;
	localparam int unsigned IDX_W    = (IW_A > GUARD_CW) ? IW_A : GUARD_CW;
	localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_BITS) - 64'd1;

	req_t        req_q;
	logic [63:0] end_q;
	logic        rng_ok_q, bus_ok_q, aper_in_q;
	logic [63:0] aper_lb_q, aper_le_q, aper_hb_q, aper_he_q;

	logic [MAP_CW-1:0]   map_cnt_q;
	logic [ECAM_CW-1:0]  ecam_cnt_q;
	logic [GUARD_CW-1:0] guard_cnt_q;

	logic [63:0] map_start_mem [MAP_DEPTH];
	logic [63:0] map_pages_mem [MAP_DEPTH];
	logic [3:0]  map_kind_mem  [MAP_DEPTH];
	logic [63:0] ecam_start_mem [ECAM_DEPTH];
	logic [63:0] ecam_limit_mem [ECAM_DEPTH];
	logic [63:0] guard_start_mem [GUARD_DEPTH];
	logic [63:0] guard_limit_mem [GUARD_DEPTH];

	logic [63:0] map_start_rd, map_pages_rd, ecam_start_rd, ecam_limit_rd;
	logic [63:0] guard_start_rd, guard_limit_rd;
	logic [3:0]  map_kind_rd;

	tbl_t             tbl_q;
	logic             run_q, s1_vld, s2_vld;
	logic [IDX_W-1:0] idx_q, lim;
	logic             iss;
	logic [63:0]      s2_start, s2_end;
	logic             s2_ovf;
	logic [3:0]       s2_kind;
	logic             guard_hit_q, conv_hit_q, mmio_in_q, fw_in_q, ecam_found_q, ecam_in_q;

	logic [8:0]  bus_cnt;
	logic [63:0] len_sel;
	logic [64:0] sum;
	logic        hit, held;
	logic [63:0] s1_start, s1_aux, pg_bytes;
	logic [64:0] map_sum;
	logic        full_sel;

	// request latch and range check
	always_comb begin
		bus_cnt = {1'b0, req_q.end_bus} - {1'b0, req_q.first_bus} + 9'd1;
		if (req_q.req_type == REQ_ECAM) begin
			len_sel = 64'(bus_cnt) << ECAM_BUS_SHIFT;
		end else begin
			len_sel = req_q.length;
		end
		sum = {1'b0, req_q.base} + {1'b0, len_sel};
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req;
		end
		if (cmd.prep) begin
			end_q    <= sum[63:0];
			rng_ok_q <= (len_sel != 64'd0) && ((req_q.base & PAGE_MASK) == 64'd0) &&
				((len_sel & PAGE_MASK) == 64'd0) && !sum[64];
			bus_ok_q <= req_q.first_bus <= req_q.end_bus;
		end
		aper_in_q <= ((req_q.base >= aper_lb_q) && (end_q <= aper_le_q)) ||
			((req_q.base >= aper_hb_q) && (end_q <= aper_he_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aper_lb_q <= APER_LOW_BASE_RST;
			aper_le_q <= APER_LOW_END_RST;
			aper_hb_q <= APER_HIGH_BASE_RST;
			aper_he_q <= APER_HIGH_END_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_APER_LOW_BASE:  aper_lb_q <= cfg_data;
				CFG_APER_LOW_END:   aper_le_q <= cfg_data;
				CFG_APER_HIGH_BASE: aper_hb_q <= cfg_data;
				CFG_APER_HIGH_END:  aper_he_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// table fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_cnt_q   <= '0;
			ecam_cnt_q  <= '0;
			guard_cnt_q <= '0;
		end else if (cmd.wr_en) begin
			unique case (cmd.tbl)
				TBL_MAP:   map_cnt_q   <= map_cnt_q + MAP_CW'(1);
				TBL_ECAM:  ecam_cnt_q  <= ecam_cnt_q + ECAM_CW'(1);
				TBL_GUARD: guard_cnt_q <= guard_cnt_q + GUARD_CW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && cmd.tbl == TBL_MAP) begin
			map_start_mem[map_cnt_q[MAP_AW-1:0]] <= req_q.base;
			map_pages_mem[map_cnt_q[MAP_AW-1:0]] <= req_q.pages;
			map_kind_mem[map_cnt_q[MAP_AW-1:0]]  <= req_q.mem_type;
		end
		if (iss) begin
			map_start_rd <= map_start_mem[idx_q[MAP_AW-1:0]];
			map_pages_rd <= map_pages_mem[idx_q[MAP_AW-1:0]];
			map_kind_rd  <= map_kind_mem[idx_q[MAP_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && cmd.tbl == TBL_ECAM) begin
			ecam_start_mem[ecam_cnt_q[ECAM_AW-1:0]] <= req_q.base;
			ecam_limit_mem[ecam_cnt_q[ECAM_AW-1:0]] <= end_q;
		end
		if (iss) begin
			ecam_start_rd <= ecam_start_mem[idx_q[ECAM_AW-1:0]];
			ecam_limit_rd <= ecam_limit_mem[idx_q[ECAM_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && cmd.tbl == TBL_GUARD) begin
			guard_start_mem[guard_cnt_q[GUARD_AW-1:0]] <= req_q.base;
			guard_limit_mem[guard_cnt_q[GUARD_AW-1:0]] <= end_q;
		end
		if (iss) begin
			guard_start_rd <= guard_start_mem[idx_q[GUARD_AW-1:0]];
			guard_limit_rd <= guard_limit_mem[idx_q[GUARD_AW-1:0]];
		end
	end

	// table walk
	always_comb begin
		unique case (tbl_q)
			TBL_MAP:   lim = IDX_W'(map_cnt_q);
			TBL_ECAM:  lim = IDX_W'(ecam_cnt_q);
			default:   lim = IDX_W'(guard_cnt_q);
		endcase
		iss = run_q && (idx_q < lim);
		unique case (tbl_q)
			TBL_MAP:  begin s1_start = map_start_rd;   s1_aux = map_pages_rd;   end
			TBL_ECAM: begin s1_start = ecam_start_rd;  s1_aux = ecam_limit_rd;  end
			default:  begin s1_start = guard_start_rd; s1_aux = guard_limit_rd; end
		endcase
		pg_bytes = s1_aux << PAGE_BITS;
		map_sum  = {1'b0, s1_start} + {1'b0, pg_bytes};
		hit      = (req_q.base < s2_end) && (s2_start < end_q);
		held     = (req_q.base >= s2_start) && (end_q <= s2_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			s1_vld <= 1'b0;
			s2_vld <= 1'b0;
			idx_q  <= '0;
			tbl_q  <= TBL_GUARD;
		end else begin
			s1_vld <= iss;
			s2_vld <= s1_vld;
			if (cmd.scan_start) begin
				run_q <= 1'b1;
				idx_q <= '0;
				tbl_q <= cmd.tbl;
			end else if (iss) begin
				idx_q <= idx_q + IDX_W'(1);
			end else begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_vld) begin
			s2_start <= s1_start;
			s2_kind  <= map_kind_rd;
			if (tbl_q == TBL_MAP) begin
				s2_end <= map_sum[63:0];
				s2_ovf <= ((s1_aux >> (64 - PAGE_BITS)) != 64'd0) || map_sum[64];
			end else begin
				s2_end <= s1_aux;
				s2_ovf <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			guard_hit_q  <= 1'b0;
			conv_hit_q   <= 1'b0;
			mmio_in_q    <= 1'b0;
			fw_in_q      <= 1'b0;
			ecam_found_q <= 1'b0;
			ecam_in_q    <= 1'b0;
		end else if (s2_vld) begin
			unique case (tbl_q)
				TBL_GUARD: begin
					if (hit) guard_hit_q <= 1'b1;
				end
				TBL_MAP: begin
					if (s2_kind == MEM_CONV && (s2_ovf || hit)) conv_hit_q <= 1'b1;
					if (!s2_ovf && held && s2_kind == MEM_MMIO) mmio_in_q <= 1'b1;
					if (!s2_ovf && held && (s2_kind == MEM_RECLAIM || s2_kind == MEM_NVS))
						fw_in_q <= 1'b1;
				end
				TBL_ECAM: begin
					if (!ecam_found_q && hit) begin
						ecam_found_q <= 1'b1;
						ecam_in_q    <= held;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (req_q.req_type)
			REQ_MAP:     full_sel = map_cnt_q == MAP_CW'(MAP_DEPTH);
			REQ_ECAM:    full_sel = ecam_cnt_q == ECAM_CW'(ECAM_DEPTH);
			REQ_PROTECT: full_sel = guard_cnt_q == GUARD_CW'(GUARD_DEPTH);
			default:     full_sel = 1'b0;
		endcase
		sts.req_type   = req_q.req_type;
		sts.rng_ok     = rng_ok_q;
		sts.bus_ok     = bus_ok_q;
		sts.flags_ok   = (req_q.flags[7:4] == 4'd0) && req_q.flags[FL_READ] &&
			!req_q.flags[FL_WC];
		sts.fw_req     = req_q.flags[FL_FW];
		sts.wr_req     = req_q.flags[FL_WRITE];
		sts.full       = full_sel;
		sts.busy       = run_q || s1_vld || s2_vld;
		sts.guard_hit  = guard_hit_q;
		sts.conv_hit   = conv_hit_q;
		sts.mmio_in    = mmio_in_q;
		sts.fw_in      = fw_in_q;
		sts.ecam_found = ecam_found_q;
		sts.ecam_in    = ecam_in_q;
		sts.aper_in    = aper_in_q;
	end

	a_map_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		map_cnt_q <= MAP_CW'(MAP_DEPTH)) else $error("map count beyond depth");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |-> !(run_q || s1_vld || s2_vld)) else $error("walk restarted while busy");
	a_wr_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> !full_sel) else $error("write into full table");

endmodule
`default_nettype wire

@@ hw/rtl/dmrc_ctrl.sv @@
`default_nettype none
module dmrc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output dmrc_pkg::rsp_t      rsp,
	input  wire dmrc_pkg::sts_t sts,
	output dmrc_pkg::cmd_t      cmd
);
	import dmrc_pkg::*;

	state_t state_q, state_d;
	rsp_t   res_q, res_d;
	logic   res_ld;
	logic   rsp_valid_q;
	rsp_t   rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FINISH && !(rsp_valid_q && rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_q <= res_d;
		end
		if (state_q == ST_FINISH && !(rsp_valid_q && rsp_stall)) begin
			rsp_q <= res_q;
		end
	end

	always_comb begin
		state_d        = state_q;
		cmd.latch      = 1'b0;
		cmd.prep       = 1'b0;
		cmd.wr_en      = 1'b0;
		cmd.scan_start = 1'b0;
		cmd.tbl        = TBL_GUARD;
		res_ld         = 1'b0;
		res_d          = '{ok: 1'b0, mapping_class: CLASS_NONE, delegatable: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_CHECK;
			end
			ST_CHECK: begin
				res_ld  = 1'b1;
				state_d = ST_FINISH;
				unique case (req_kind_t'(sts.req_type))
					REQ_MAP: begin
						cmd.tbl   = TBL_MAP;
						cmd.wr_en = !sts.full;
					end
					REQ_ECAM: begin
						cmd.tbl   = TBL_ECAM;
						cmd.wr_en = !sts.full && sts.rng_ok && sts.bus_ok;
					end
					REQ_PROTECT: begin
						cmd.tbl   = TBL_GUARD;
						cmd.wr_en = !sts.full && sts.rng_ok;
					end
					default: begin
						if (sts.rng_ok && sts.flags_ok) begin
							res_ld         = 1'b0;
							cmd.scan_start = 1'b1;
							cmd.tbl        = TBL_GUARD;
							state_d        = ST_GUARD;
						end
					end
				endcase
				res_d.ok = cmd.wr_en;
			end
			ST_GUARD: begin
				if (!sts.busy) begin
					if (sts.guard_hit || (sts.fw_req && sts.wr_req)) begin
						res_ld  = 1'b1;
						state_d = ST_FINISH;
					end else begin
						cmd.scan_start = 1'b1;
						cmd.tbl        = TBL_MAP;
						state_d        = ST_MAP;
					end
				end
			end
			ST_MAP: begin
				cmd.tbl = TBL_MAP;
				if (!sts.busy) begin
					if (sts.fw_req) begin
						res_ld  = 1'b1;
						state_d = ST_FINISH;
						if (sts.fw_in) begin
							res_d = '{ok: 1'b1, mapping_class: CLASS_PRISTINE, delegatable: 1'b0};
						end
					end else if (sts.conv_hit) begin
						res_ld  = 1'b1;
						state_d = ST_FINISH;
					end else begin
						cmd.scan_start = 1'b1;
						cmd.tbl        = TBL_ECAM;
						state_d        = ST_ECAM;
					end
				end
			end
			ST_ECAM: begin
				cmd.tbl = TBL_ECAM;
				if (!sts.busy) begin
					res_ld  = 1'b1;
					state_d = ST_FINISH;
					if (sts.ecam_found) begin
						if (sts.ecam_in) begin
							res_d = '{ok: 1'b1, mapping_class: CLASS_UC, delegatable: 1'b0};
						end
					end else if (sts.aper_in || sts.mmio_in) begin
						res_d = '{ok: 1'b1, mapping_class: CLASS_UC, delegatable: 1'b1};
					end
				end
			end
			ST_FINISH: begin
				if (!(rsp_valid_q && rsp_stall)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_one_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && state_d == ST_IDLE) |=> rsp_valid) else $error("result lost");
	a_grant_class: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.mapping_class == CLASS_NONE) |-> !rsp.delegatable)
		else $error("delegatable without class");
	a_scan_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |=> (state_q == ST_GUARD || state_q == ST_MAP || state_q == ST_ECAM))
		else $error("walk started outside a walk state");

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import dmrc_pkg::*;

	class grant_board;
		rsp_t pending[$];
		int errors;
		logic [63:0] aper[4];
		logic [63:0] m_start[$];
		logic [63:0] m_pages[$];
		logic [3:0] m_kind[$];
		logic [63:0] e_start[$];
		logic [63:0] e_limit[$];
		logic [63:0] g_start[$];
		logic [63:0] g_limit[$];

		function void clear();
			aper[CFG_APER_LOW_BASE] = APER_LOW_BASE_RST;
			aper[CFG_APER_LOW_END] = APER_LOW_END_RST;
			aper[CFG_APER_HIGH_BASE] = APER_HIGH_BASE_RST;
			aper[CFG_APER_HIGH_END] = APER_HIGH_END_RST;
			m_start.delete(); m_pages.delete(); m_kind.delete();
			e_start.delete(); e_limit.delete(); g_start.delete(); g_limit.delete();
			pending.delete();
			errors = 0;
		endfunction

		function bit range_ok(logic [63:0] b, logic [63:0] len, output logic [63:0] e);
			logic [64:0] s;
			logic [63:0] pm;
			pm = (64'd1 << DEF_PAGE_BITS) - 1;
			s = {1'b0, b} + {1'b0, len};
			e = s[63:0];
			return len != 0 && (b & pm) == 0 && (len & pm) == 0 && !s[64];
		endfunction

		function bit entry_limit(int i, output logic [63:0] e);
			logic [64:0] s;
			if ((m_pages[i] >> (64 - DEF_PAGE_BITS)) != 0) return 0;
			s = {1'b0, m_start[i]} + {1'b0, m_pages[i] << DEF_PAGE_BITS};
			e = s[63:0];
			return !s[64];
		endfunction

		function bit kind_covers(logic [3:0] k, logic [63:0] b, logic [63:0] e);
			logic [63:0] me;
			foreach (m_start[i])
				if (entry_limit(i, me) && m_kind[i] == k && b >= m_start[i] && e <= me)
					return 1;
			return 0;
		endfunction

		function rsp_t decide(req_t r);
			rsp_t o;
			logic [63:0] e, me;
			logic [8:0] nb;
			o = '0;
			case (req_kind_t'(r.req_type))
				REQ_MAP: if (m_start.size() < DEF_MAP_DEPTH) begin
					m_start.push_back(r.base); m_pages.push_back(r.pages);
					m_kind.push_back(r.mem_type); o.ok = 1;
				end
				REQ_ECAM: begin
					nb = {1'b0, r.end_bus} - {1'b0, r.first_bus} + 9'd1;
					if (e_start.size() < DEF_ECAM_DEPTH && r.first_bus <= r.end_bus &&
							range_ok(r.base, 64'(nb) << ECAM_BUS_SHIFT, e)) begin
						e_start.push_back(r.base); e_limit.push_back(e); o.ok = 1;
					end
				end
				REQ_PROTECT: if (g_start.size() < DEF_GUARD_DEPTH && range_ok(r.base, r.length, e)) begin
					g_start.push_back(r.base); g_limit.push_back(e); o.ok = 1;
				end
				default: begin
					if (!range_ok(r.base, r.length, e) || r.flags[7:4] != 0 ||
							!r.flags[FL_READ] || r.flags[FL_WC]) return o;
					foreach (g_start[i])
						if (r.base < g_limit[i] && g_start[i] < e) return o;
					if (r.flags[FL_FW]) begin
						if (r.flags[FL_WRITE]) return o;
						if (!kind_covers(MEM_RECLAIM, r.base, e) && !kind_covers(MEM_NVS, r.base, e))
							return o;
						o.ok = 1; o.mapping_class = CLASS_PRISTINE;
						return o;
					end
					foreach (m_start[i])
						if (m_kind[i] == MEM_CONV) begin
							if (!entry_limit(i, me)) return o;
							if (r.base < me && m_start[i] < e) return o;
						end
					foreach (e_start[i])
						if (r.base < e_limit[i] && e_start[i] < e) begin
							if (!(r.base >= e_start[i] && e <= e_limit[i])) return o;
							o.ok = 1; o.mapping_class = CLASS_UC;
							return o;
						end
					if (!(r.base >= aper[CFG_APER_LOW_BASE] && e <= aper[CFG_APER_LOW_END]) &&
							!(r.base >= aper[CFG_APER_HIGH_BASE] && e <= aper[CFG_APER_HIGH_END]) &&
							!kind_covers(MEM_MMIO, r.base, e)) return o;
					o.ok = 1; o.mapping_class = CLASS_UC; o.delegatable = 1;
				end
			endcase
			return o;
		endfunction

		function void note_request(req_t r);
			pending.push_back(decide(r));
		endfunction

		function void check_response(rsp_t a);
			rsp_t x;
			if (pending.size() == 0) begin
				$error("unexpected transaction ok=%0d", a.ok);
				errors++;
				return;
			end
			x = pending.pop_front();
			if (a.ok !== x.ok) begin
				$error("ok expected %0d actual %0d", x.ok, a.ok); errors++;
			end
			if (a.mapping_class !== x.mapping_class) begin
				$error("mapping_class expected %0d actual %0d", x.mapping_class, a.mapping_class);
				errors++;
			end
			if (a.delegatable !== x.delegatable) begin
				$error("delegatable expected %0d actual %0d", x.delegatable, a.delegatable);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, req_valid, req_stall, rsp_valid, rsp_stall, cfg_we;
	req_t req;
	rsp_t rsp;
	logic [1:0] cfg_index;
	logic [63:0] cfg_data;
	grant_board board;
	bit calm;

	device_mapping_range_checker_core dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[device_mapping_range_checker_core] ERROR");
		$finish;
	end

	// response side: random stall bursts, check on accept
	initial begin
		int n;
		rsp_stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) board.check_response(rsp);
			@(negedge clk);
			if (n > 0) n--;
			else if (!calm && $urandom_range(0, 9) == 0) n = $urandom_range(1, 12);
			rsp_stall = (n > 0);
		end
	end

	task automatic send(req_t r);
		if (!calm && $urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 12)) @(negedge clk);
		req = r;
		req_valid = 1;
		do @(posedge clk); while (req_stall);
		board.note_request(r);
		@(negedge clk);
		req_valid = 0;
	endtask

	task automatic write_reg(cfg_idx_t i, logic [63:0] v);
		while (board.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		cfg_index = i; cfg_data = v; cfg_we = 1;
		@(negedge clk);
		cfg_we = 0;
		board.aper[i] = v;
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_addr();
		case ($urandom_range(0, 5))
			0: return rnd64();
			1: return 64'($urandom_range(0, 255)) << 12;
			2: return APER_LOW_BASE_RST + (64'($urandom_range(0, 500)) << 12);
			3: return APER_HIGH_BASE_RST + (64'($urandom_range(0, 500)) << 12);
			4: return ({$urandom, $urandom} & ~64'hFFF);
			default: return 64'h1000_0000 + (64'($urandom_range(0, 300)) << 12);
		endcase
	endfunction

	function automatic req_t rand_req(bit wide);
		req_t r;
		logic [223:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r = raw[$bits(req_t)-1:0];
		r.base = pick_addr();
		r.length = wide && $urandom_range(0, 3) == 0 ? rnd64() : 64'($urandom_range(1, 64)) << 12;
		r.pages = wide && $urandom_range(0, 4) == 0 ? rnd64() : 64'($urandom_range(1, 300));
		if ($urandom_range(0, 2) != 0)
			r.mem_type = $urandom_range(0, 1) ? MEM_MMIO : 4'($urandom_range(7, 11));
		if (!wide || $urandom_range(0, 2) != 0) r.flags = {4'h0, 4'($urandom_range(0, 15))} | 8'h1;
		if (!wide) begin
			r.end_bus = r.first_bus + 8'($urandom_range(0, 3));
			r.base = 64'h1000_0000 + (64'($urandom_range(0, 40)) << 20);
		end
		return r;
	endfunction

	task automatic phase(int count);
		req_t r;
		repeat (count) begin
			r = rand_req($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0, 1: r.req_type = REQ_MAP;
				2: r.req_type = REQ_ECAM;
				3: r.req_type = REQ_PROTECT;
				default: r.req_type = REQ_VALIDATE;
			endcase
			if (r.req_type == REQ_ECAM) begin
				r.end_bus = r.first_bus + 8'($urandom_range(0, 3));
				if ($urandom_range(0, 1)) r.base = 64'h1000_0000 + (64'($urandom_range(0, 40)) << 20);
			end
			send(r);
		end
	endtask

	initial begin
		req_t r;
		board = new();
		board.clear();
		arst_n = 0; req_valid = 0; req = '0; cfg_we = 0; cfg_index = CFG_APER_LOW_BASE;
		cfg_data = '0; calm = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed
		r = '0; r.req_type = REQ_VALIDATE; r.flags = 8'h01;
		r.base = APER_LOW_BASE_RST; r.length = 64'h1000; send(r);
		r.length = 0; send(r);
		r.length = 64'h1001; send(r);
		r.base = 64'hFFFF_FFFF_FFFF_F000; r.length = 64'h2000; send(r);
		r.base = APER_HIGH_BASE_RST; r.length = 64'h1000; r.flags = 8'hF1; send(r);
		r.flags = 8'h05; send(r);
		r.flags = 8'h02; send(r);
		r.flags = 8'h03; send(r);
		r.req_type = REQ_MAP; r.base = 64'h2000_0000; r.pages = 16; r.mem_type = MEM_NVS; send(r);
		r.base = 64'h3000_0000; r.mem_type = MEM_RECLAIM; send(r);
		r.base = 64'h4000_0000; r.mem_type = MEM_MMIO; send(r);
		r.base = 64'h5000_0000; r.mem_type = MEM_CONV; send(r);
		r.req_type = REQ_VALIDATE; r.flags = 8'h09; r.base = 64'h2000_0000; r.length = 64'h2000; send(r);
		r.base = 64'h3000_0000; send(r);
		r.flags = 8'h0B; send(r);
		r.flags = 8'h03; r.base = 64'h4000_0000; send(r);
		r.base = 64'h5000_0000; send(r);
		r.req_type = REQ_ECAM; r.base = 64'hE000_0000; r.first_bus = 0; r.end_bus = 8'hFF; send(r);
		r.first_bus = 5; r.end_bus = 4; send(r);
		r.base = 64'hFFFF_FFFF_FFF0_0000; r.first_bus = 0; r.end_bus = 1; send(r);
		r.req_type = REQ_VALIDATE; r.base = 64'hE000_0000; r.length = 64'h1000; send(r);
		r.base = 64'hDFFF_F000; r.length = 64'h2000; send(r);
		r.req_type = REQ_PROTECT; r.base = 64'hC000_0000; r.length = 64'h1000; send(r);
		r.req_type = REQ_VALIDATE; r.base = 64'hC000_0000; send(r);
		r.req_type = REQ_MAP; r.base = 64'hFFFF_FFFF_FFFF_0000; r.pages = '1; r.mem_type = MEM_CONV;
		send(r);

		phase(60);
		write_reg(CFG_APER_LOW_BASE, 64'h0);
		write_reg(CFG_APER_LOW_END, 64'hFFFF_FFFF_FFFF_FFFF);
		phase(80);
		write_reg(CFG_APER_HIGH_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(CFG_APER_HIGH_END, 64'h0);
		write_reg(CFG_APER_LOW_BASE, 64'h1000_0000);
		write_reg(CFG_APER_LOW_END, 64'h2000_0000);
		phase(150);
		write_reg(CFG_APER_HIGH_BASE, APER_HIGH_BASE_RST);
		write_reg(CFG_APER_HIGH_END, 64'hFFFF_FFFF_FFFF_FFFF);
		phase(80);
		calm = 1;
		phase(60);

		fork
			while (board.pending.size() != 0) @(negedge clk);
			begin
				repeat (100000) @(negedge clk);
				board.errors++;
			end
		join_any
		disable fork;
		repeat (300) @(negedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("[device_mapping_range_checker_core] OK");
		else
			$display("[device_mapping_range_checker_core] ERROR");
		$finish;
	end
endmodule
`default_nettype wire

@@ files.f @@
hw/rtl/dmrc_pkg.sv
hw/rtl/dmrc_dp.sv
hw/rtl/dmrc_ctrl.sv
hw/rtl/device_mapping_range_checker_core.sv
test/tb_top.sv
